>>> src/tcw_pkg.sv
// Shared constants for the text console writer.
// Holds character codes, command codes and cell formats; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

  // Width of one stored cell: attribute in the high byte, character in the low byte.
  localparam int CELL_W = 16;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Attribute after reset and the blank cell that reset leaves everywhere.
  localparam logic [7:0]        RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

endpackage

>>> src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the console cell store; depends on nothing.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/text_console_writer.sv
// Top level of the text console writer: sequencer, cursor and window state.
// Depends on tcw_pkg and on tcw_ram for the cell store.
`timescale 1ns / 1ps

// Usage
// A command beat is taken when start is high and busy is low. cmd selects a
// character write or a read of one cell of the visible window. Every command
// gives exactly one result: done is high for one cycle with cell_data (zero
// for writes) and cursor_offset, the cursor position from the top of the
// window. The receiver cannot stall; it must take the result in that cycle.
// The attribute register is written over the cfg channel (cfg_ready is
// always high) and should only be changed while busy is low.
// A scroll blanks the new line; when the store is full it first moves the
// store up one line, a cell per cycle, through the single RAM port pair.
// After reset the block clears the store to spaces with attribute 7, one cell
// a cycle; busy stays high until that is done.
// One command is in flight at a time; busy is high while it is worked on.

module text_console_writer #(
  parameter int LINE_WIDTH   = 80,
  parameter int SCREEN_ROWS  = 25,
  parameter int BUFFER_CELLS = 4000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  char_code,
  input  logic [10:0] read_index,
  output logic        done,
  output logic [15:0] cell_data,
  output logic [10:0] cursor_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import tcw_pkg::*;

  localparam int WINDOW_CELLS = LINE_WIDTH * SCREEN_ROWS;
  localparam int POS_RAW = $clog2(BUFFER_CELLS + WINDOW_CELLS + 3 * LINE_WIDTH);
  localparam int POS_W   = (POS_RAW > 12) ? POS_RAW : 12;
  localparam int ADDR_W  = $clog2(BUFFER_CELLS);
  localparam int CNT_MAX = (BUFFER_CELLS > LINE_WIDTH) ? BUFFER_CELLS : LINE_WIDTH;
  localparam int CNT_W   = $clog2(CNT_MAX);
  localparam int COL_W   = $clog2(LINE_WIDTH);

  localparam logic [POS_W-1:0] LW_P = POS_W'(LINE_WIDTH);
  localparam logic [POS_W-1:0] WC_P = POS_W'(WINDOW_CELLS);
  localparam logic [POS_W-1:0] BC_P = POS_W'(BUFFER_CELLS);
  localparam logic [CNT_W-1:0] CNT_LW      = CNT_W'(LINE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LW_LAST = CNT_W'(LINE_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_BC_LAST = CNT_W'(BUFFER_CELLS - 1);
  localparam logic [COL_W-1:0] COL_LAST    = COL_W'(LINE_WIDTH - 1);

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b0000_0000_0001,
    S_IDLE       = 12'b0000_0000_0010,
    S_RDWAIT     = 12'b0000_0000_0100,
    S_LF         = 12'b0000_0000_1000,
    S_ADV        = 12'b0000_0001_0000,
    S_SCROLL     = 12'b0000_0010_0000,
    S_SHIFT      = 12'b0000_0100_0000,
    S_SHIFT_END  = 12'b0000_1000_0000,
    S_LOWER      = 12'b0001_0000_0000,
    S_BLANK      = 12'b0010_0000_0000,
    S_SCROLL_END = 12'b0100_0000_0000,
    S_DONE       = 12'b1000_0000_0000
  } state_t;

  state_t              state;
  logic [7:0]          text_attr;
  logic [POS_W-1:0]    window_top;
  logic [POS_W-1:0]    cursor_pos;
  logic [COL_W-1:0]    cursor_col;
  logic [CNT_W-1:0]    sweep;
  logic [POS_W-1:0]    blank_addr;
  logic                shift_pend;
  logic [ADDR_W-1:0]   shift_waddr;
  logic                pend_inc;
  logic                rd_zero;
  logic [CELL_W-1:0]   data_reg;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  logic [POS_W-1:0]    rd_addr;
  logic                rd_ok;
  logic                is_print;
  logic [POS_W-1:0]    window_end;
  logic [COL_W-1:0]    col_step;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Address decode for the incoming command.
  assign rd_addr    = window_top + POS_W'(read_index);
  assign rd_ok      = (POS_W'(read_index) < WC_P) && (rd_addr < BC_P);
  assign is_print   = (char_code != CH_CR) && (char_code != CH_LF);
  assign window_end = window_top + WC_P;
  assign col_step   = (cursor_col == COL_LAST) ? '0 : cursor_col + 1'b1;

  // RAM port steering; the delayed write of a store shift takes precedence.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep[ADDR_W-1:0];
        mem_wdata = RESET_CELL;
      end
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_READ) begin
            mem_re    = rd_ok;
            mem_raddr = rd_addr[ADDR_W-1:0];
          end else if (is_print && (cursor_pos < BC_P)) begin
            mem_we    = 1'b1;
            mem_waddr = cursor_pos[ADDR_W-1:0];
            mem_wdata = {text_attr, char_code};
          end
        end
      end
      S_SHIFT: begin
        mem_re    = 1'b1;
        mem_raddr = sweep[ADDR_W-1:0];
      end
      S_BLANK: begin
        if (blank_addr < BC_P) begin
          mem_we    = 1'b1;
          mem_waddr = blank_addr[ADDR_W-1:0];
          mem_wdata = {text_attr, CH_SPACE};
        end
      end
      default: begin
      end
    endcase
    if (shift_pend) begin
      mem_we    = 1'b1;
      mem_waddr = shift_waddr;
      mem_wdata = mem_rdata;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (BUFFER_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Attribute register, written from the configuration channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      text_attr <= cfg_data;
    end
  end

  // Command sequencer: cursor moves, scrolling, store shift and result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep      <= '0;
      window_top <= '0;
      cursor_pos <= '0;
      cursor_col <= '0;
      shift_pend <= 1'b0;
      pend_inc   <= 1'b0;
      done       <= 1'b0;
    end else begin
      // The result strobe is high in the cycle after the finishing step.
      done <= (state == S_DONE);
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == CNT_BC_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            data_reg <= '0;
            pend_inc <= (cmd != CMD_READ) && is_print;
            if (cmd == CMD_READ) begin
              rd_zero <= !rd_ok;
              state   <= S_RDWAIT;
            end else if (char_code == CH_CR) begin
              cursor_pos <= cursor_pos - POS_W'(cursor_col);
              cursor_col <= '0;
              state      <= S_DONE;
            end else if (char_code == CH_LF) begin
              cursor_pos <= cursor_pos - POS_W'(cursor_col) + LW_P;
              cursor_col <= '0;
              state      <= S_LF;
            end else begin
              state    <= S_ADV;
            end
          end
        end
        S_RDWAIT: begin
          data_reg <= rd_zero ? '0 : mem_rdata;
          state    <= S_DONE;
        end
        S_LF: begin
          state <= (cursor_pos >= window_end) ? S_SCROLL : S_DONE;
        end
        S_ADV: begin
          if (cursor_pos == window_end - 1'b1) begin
            state <= S_SCROLL;
          end else begin
            cursor_pos <= cursor_pos + 1'b1;
            cursor_col <= col_step;
            state      <= S_DONE;
          end
        end
        S_SCROLL: begin
          if (window_end >= BC_P) begin
            if (BUFFER_CELLS > LINE_WIDTH) begin
              sweep <= CNT_LW;
              state <= S_SHIFT;
            end else begin
              state <= S_LOWER;
            end
          end else begin
            blank_addr <= window_end;
            sweep      <= '0;
            state      <= S_BLANK;
          end
        end
        // Read cell i each cycle; it lands one line lower on the next cycle.
        S_SHIFT: begin
          shift_pend  <= 1'b1;
          shift_waddr <= ADDR_W'(sweep - CNT_LW);
          sweep       <= sweep + 1'b1;
          if (sweep == CNT_BC_LAST) begin
            state <= S_SHIFT_END;
          end
        end
        S_SHIFT_END: begin
          shift_pend <= 1'b0;
          state      <= S_LOWER;
        end
        S_LOWER: begin
          if (window_top >= LW_P) begin
            window_top <= window_top - LW_P;
            cursor_pos <= cursor_pos - LW_P;
            blank_addr <= window_end - LW_P;
          end else begin
            blank_addr <= window_end;
          end
          sweep <= '0;
          state <= S_BLANK;
        end
        S_BLANK: begin
          blank_addr <= blank_addr + 1'b1;
          sweep      <= sweep + 1'b1;
          if (sweep == CNT_LW_LAST) begin
            state <= S_SCROLL_END;
          end
        end
        S_SCROLL_END: begin
          window_top <= window_top + LW_P;
          if (pend_inc) begin
            cursor_pos <= cursor_pos + 1'b1;
            cursor_col <= col_step;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          cell_data     <= data_reg;
          cursor_offset <= 11'(cursor_pos - window_top);
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result beat only ever follows the finishing step of a command.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_DONE))
    else $error("done raised without a finishing step");

  // The cursor never sits above the top of the window.
  assert property (@(posedge clk) disable iff (rst) cursor_pos >= window_top)
    else $error("cursor above the visible window");

  // The tracked column stays within one line.
  assert property (@(posedge clk) disable iff (rst) cursor_col <= COL_LAST)
    else $error("cursor column beyond the line");

  // A delayed shift write is only pending while the store is being moved.
  assert property (@(posedge clk) disable iff (rst)
    shift_pend |-> (state == S_SHIFT || state == S_SHIFT_END))
    else $error("shift write pending outside the store shift");

  // An accepted command keeps the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

endmodule
